// ===== src/fep_pkg.sv =====
// fep_pkg: shared types and constants for the fake exponential price unit.
// No dependencies.
package fep_pkg;

   localparam int DEFAULT_WORK_WIDTH = 192;
   localparam int VALUE_WIDTH        = 64;
   localparam int CSR_INDEX_WIDTH    = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLOOR      = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONVERSION = CSR_INDEX_WIDTH'(1);

   // saturated price, all ones
   localparam logic [VALUE_WIDTH-1:0] PRICE_SAT = {VALUE_WIDTH{1'b1}};

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } op_type;

   typedef struct packed {
      logic   go;
      op_type op;
   } unit_ctrl_type;

endpackage

// ===== src/fep_muldiv.sv =====
// fep_muldiv: shared bit-serial unit, WORK_WIDTH x 64 multiply (truncated)
// and WORK_WIDTH / 64 restoring divide. Depends on fep_pkg.
module fep_muldiv #(
   parameter int WORK_WIDTH = fep_pkg::DEFAULT_WORK_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fep_pkg::unit_ctrl_type          ctrl,
   input  logic [WORK_WIDTH-1:0]           opa,
   input  logic [fep_pkg::VALUE_WIDTH-1:0] opb,
   output logic                            done,
   output logic [WORK_WIDTH-1:0]           result
);

   localparam int VW = fep_pkg::VALUE_WIDTH;
   localparam int CW = $clog2(WORK_WIDTH);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   fep_pkg::op_type       op_ff, op_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [WORK_WIDTH-1:0] opa_ff, opa_in;
   logic [VW-1:0]         opb_ff, opb_in;
   logic [WORK_WIDTH-1:0] res_ff, res_in;
   logic [VW-1:0]         rem_ff, rem_in;
   logic [VW:0]           trial;
   logic                  qbit;

   // partial remainder with the next dividend bit shifted in
   assign trial = {rem_ff, res_ff[WORK_WIDTH-1]};
   assign qbit  = (trial >= {1'b0, opb_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      if (busy_ff) begin
         case (op_ff)
            fep_pkg::OP_MUL: begin
               res_in = (res_ff << 1) + (opb_ff[VW-1] ? opa_ff : '0);
               opb_in = opb_ff << 1;
            end
            fep_pkg::OP_DIV: begin
               res_in = {res_ff[WORK_WIDTH-2:0], qbit};
               rem_in = qbit ? VW'(trial - {1'b0, opb_ff}) : trial[VW-1:0];
            end
            default: begin
               res_in = res_ff;
            end
         endcase
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctrl.go) begin
         busy_in = 1'b1;
         op_in   = ctrl.op;
         opa_in  = opa;
         opb_in  = opb;
         rem_in  = '0;
         if (ctrl.op == fep_pkg::OP_MUL) begin
            res_in = '0;
            cnt_in = CW'(VW - 1);
         end else begin
            res_in = opa;
            cnt_in = CW'(WORK_WIDTH - 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== src/fake_exponential_price_unit.sv =====
// fake_exponential_price_unit: top level, sequencer and series registers.
// Depends on fep_pkg and fep_muldiv.
//
// Computes price = floor * e^(excess/K) with the integer Taylor-series
// fake exponential: acc starts at floor*K, each term is added to sum,
// then acc = acc*excess/K/n, until acc is zero; price = sum/K. Once sum
// reaches K*(2^64-1) the price saturates to all ones. K of zero returns
// the floor price. An item is taken when start is high and busy is low; busy
// stays high until the price is out. The price appears on rsp_price for
// exactly one cycle with rsp_valid high and cannot be held off, so the
// receiver must take it in that cycle. Timing is set by the one shared
// bit-serial multiply/divide unit: a multiply steps through the 64 bits of
// opb, a divide through the WORK_WIDTH bits of the dividend, and each
// hands its result back through a registered done. Busy falls at the
// edge that puts the price on rsp_price, so the next item can be taken
// at the edge that ends the result cycle. K of zero answers in the
// cycle after start. Configuration writes (index 0 floor price, index 1
// conversion constant K, others ignored) are taken only while busy is low.
module fake_exponential_price_unit #(
   parameter int WORK_WIDTH = fep_pkg::DEFAULT_WORK_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // item channel
   input  logic                                start,
   output logic                                busy,
   input  logic [fep_pkg::VALUE_WIDTH-1:0]     req_excess,
   // result channel
   output logic                                rsp_valid,
   output logic [fep_pkg::VALUE_WIDTH-1:0]     rsp_price,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fep_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fep_pkg::VALUE_WIDTH-1:0]     csr_data
);

   localparam int VW = fep_pkg::VALUE_WIDTH;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,  // wait for start
      S_INIT = 8'b0000_0010,  // acc = floor * K
      S_ADD  = 8'b0000_0100,  // sum += acc, or finish when acc is zero
      S_CMP  = 8'b0000_1000,  // saturation check, launch acc * excess
      S_MUL  = 8'b0001_0000,  // wait product, launch / K
      S_DIVK = 8'b0010_0000,  // wait quotient, launch / n
      S_DIVN = 8'b0100_0000,  // wait quotient, next term
      S_FIN  = 8'b1000_0000   // wait sum / K
   } state_type;

   state_type             state_ff, state_in;
   logic [VW-1:0]         floor_ff, floor_in;
   logic [VW-1:0]         conv_ff, conv_in;
   logic [VW-1:0]         excess_ff, excess_in;
   logic [VW-1:0]         n_ff, n_in;
   logic [WORK_WIDTH-1:0] acc_ff, acc_in;
   logic [WORK_WIDTH-1:0] sum_ff, sum_in;
   logic [WORK_WIDTH-1:0] limit_ff, limit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]         rsp_price_ff, rsp_price_in;

   fep_pkg::unit_ctrl_type ctrl;
   logic [WORK_WIDTH-1:0]  unit_a;
   logic [VW-1:0]          unit_b;
   logic                   unit_done;
   logic [WORK_WIDTH-1:0]  unit_res;

   logic accept;
   logic cfg_write;

   assign accept    = start && (state_ff == S_IDLE);
   assign cfg_write = csr_valid && csr_ready;

   // register file
   always_comb begin
      floor_in = floor_ff;
      conv_in  = conv_ff;
      if (cfg_write) begin
         case (csr_index)
            fep_pkg::CSR_FLOOR:      floor_in = csr_data;
            fep_pkg::CSR_CONVERSION: conv_in  = csr_data;
            default:                 floor_in = floor_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      excess_in    = excess_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      limit_in     = limit_ff;
      rsp_valid_in = 1'b0;
      rsp_price_in = rsp_price_ff;
      ctrl.go      = 1'b0;
      ctrl.op      = fep_pkg::OP_MUL;
      unit_a       = acc_ff;
      unit_b       = conv_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (conv_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_price_in = floor_ff;
               end else begin
                  excess_in = req_excess;
                  n_in      = VW'(1);
                  sum_in    = '0;
                  // K * (2^64 - 1) = (K << 64) - K
                  limit_in  = WORK_WIDTH'({conv_ff, {VW{1'b0}}}) - WORK_WIDTH'(conv_ff);
                  ctrl.go   = 1'b1;
                  ctrl.op   = fep_pkg::OP_MUL;
                  unit_a    = WORK_WIDTH'(floor_ff);
                  unit_b    = conv_ff;
                  state_in  = S_INIT;
               end
            end
         end
         S_INIT: begin
            if (unit_done) begin
               acc_in   = unit_res;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (acc_ff == '0) begin
               ctrl.go  = 1'b1;
               ctrl.op  = fep_pkg::OP_DIV;
               unit_a   = sum_ff;
               unit_b   = conv_ff;
               state_in = S_FIN;
            end else begin
               sum_in   = sum_ff + acc_ff;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (sum_ff >= limit_ff) begin
               rsp_valid_in = 1'b1;
               rsp_price_in = fep_pkg::PRICE_SAT;
               state_in     = S_IDLE;
            end else begin
               ctrl.go  = 1'b1;
               ctrl.op  = fep_pkg::OP_MUL;
               unit_a   = acc_ff;
               unit_b   = excess_ff;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (unit_done) begin
               ctrl.go  = 1'b1;
               ctrl.op  = fep_pkg::OP_DIV;
               unit_a   = unit_res;
               unit_b   = conv_ff;
               state_in = S_DIVK;
            end
         end
         S_DIVK: begin
            if (unit_done) begin
               ctrl.go  = 1'b1;
               ctrl.op  = fep_pkg::OP_DIV;
               unit_a   = unit_res;
               unit_b   = n_ff;
               state_in = S_DIVN;
            end
         end
         S_DIVN: begin
            if (unit_done) begin
               acc_in   = unit_res;
               n_in     = n_ff + VW'(1);
               state_in = S_ADD;
            end
         end
         S_FIN: begin
            if (unit_done) begin
               rsp_valid_in = 1'b1;
               rsp_price_in = unit_res[VW-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         floor_ff     <= VW'(1);
         conv_ff      <= VW'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         floor_ff     <= floor_in;
         conv_ff      <= conv_in;
      end
      excess_ff    <= excess_in;
      n_ff         <= n_in;
      acc_ff       <= acc_in;
      sum_ff       <= sum_in;
      limit_ff     <= limit_in;
      rsp_price_ff <= rsp_price_in;
   end

   fep_muldiv #(
      .WORK_WIDTH(WORK_WIDTH)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .opa   (unit_a),
      .opb   (unit_b),
      .done  (unit_done),
      .result(unit_res)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_price = rsp_price_ff;

endmodule

// ===== sim/tb_fake_exponential_price_unit.sv =====
// Testbench for fake_exponential_price_unit: directed probes, then random phases,
// every price checked, most by a 192-bit predictor. Depends on fep_pkg and the RTL.
module tb_fake_exponential_price_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORK_W          = fep_pkg::DEFAULT_WORK_WIDTH;
   localparam int VALUE_WIDTH     = fep_pkg::VALUE_WIDTH;
   localparam int CSR_INDEX_WIDTH = fep_pkg::CSR_INDEX_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLOOR      = fep_pkg::CSR_FLOOR;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONVERSION = fep_pkg::CSR_CONVERSION;
   localparam logic [VALUE_WIDTH-1:0]     PRICE_SAT      = fep_pkg::PRICE_SAT;

   // writes to these indexes must leave both registers alone
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = CSR_INDEX_WIDTH'(3);

   localparam int PROBE_COUNT = 23;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 34;
   // series-length budgets: most random items stay short, a few go deep
   localparam int SHORT_TERMS = 10;
   localparam int DEEP_TERMS  = 32;
   // worst case is ~300 items plus a few deep probes
   localparam longint CYCLE_LIMIT = 64'd20_000_000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [VALUE_WIDTH-1:0]     req_excess = '0;
   logic                       rsp_valid;
   logic [VALUE_WIDTH-1:0]     rsp_price;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [VALUE_WIDTH-1:0]     csr_data = '0;

   fake_exponential_price_unit #(
      .WORK_WIDTH(WORK_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_excess(req_excess),
      .rsp_valid (rsp_valid),
      .rsp_price (rsp_price),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor: own copy of both registers, series evaluated on WORK_W bits.
   // terms counts series additions, used only to keep random items cheap.
   // ---------------------------------------------------------------------------
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] price;
      logic [31:0]            terms;
   } price_estimate_type;

   logic [VALUE_WIDTH-1:0] floor_price = 64'd1;   // register 0 after reset
   logic [VALUE_WIDTH-1:0] k_divisor   = 64'd1;   // register 1 after reset

   function automatic price_estimate_type fake_exp_price(input logic [VALUE_WIDTH-1:0] excess,
                                                         input logic [VALUE_WIDTH-1:0] base,
                                                         input logic [VALUE_WIDTH-1:0] k_div);
      price_estimate_type est;
      bit [WORK_W-1:0] sum, acc, ceiling, xw, kw, bw, nw;
      est.terms = '0;
      // K of zero: the floor price passes straight through
      if (k_div == '0) begin
         est.price = base;
         return est;
      end
      xw      = WORK_W'(excess);
      kw      = WORK_W'(k_div);
      bw      = WORK_W'(base);
      nw      = WORK_W'(1);
      sum     = '0;
      acc     = bw * kw;
      ceiling = kw * WORK_W'(PRICE_SAT);
      while (acc != '0) begin
         sum       = sum + acc;
         est.terms = est.terms + 32'd1;
         // saturate as soon as the running sum reaches K*(2^64-1)
         if (sum >= ceiling) begin
            est.price = PRICE_SAT;
            return est;
         end
         acc = acc * xw;
         acc = acc / kw;
         acc = acc / nw;
         nw  = nw + WORK_W'(1);
      end
      sum       = sum / kw;
      est.price = sum[VALUE_WIDTH-1:0];
      return est;
   endfunction

   // ---------------------------------------------------------------------------
   // Result check: one price per accepted item, in order.
   // ---------------------------------------------------------------------------
   logic [VALUE_WIDTH-1:0] pending_prices [$];
   int                     fault_count = 0;
   longint                 cycle_count = 0;

   always @(posedge clock) begin : price_check
      logic [VALUE_WIDTH-1:0] want;
      if (!reset && rsp_valid) begin
         if (pending_prices.size() == 0) begin
            $error("price: no item outstanding, got %h", rsp_price);
            fault_count++;
         end else begin
            want = pending_prices.pop_front();
            if (rsp_price !== want) begin
               $error("price: expected %h, got %h", want, rsp_price);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Drivers: everything changes at the falling edge, handshakes are judged
   // on values sampled at the rising edge.
   // ---------------------------------------------------------------------------

   // One item. Before start goes up there may be a short idle burst; while the
   // unit is busy start may also drop for a burst, so idles land on every
   // phase of the series. calm turns both off.
   task automatic send_excess(input logic [VALUE_WIDTH-1:0] x,
                              input logic [VALUE_WIDTH-1:0] want,
                              input bit calm);
      if (!calm && $urandom_range(0, 2) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      start      <= 1'b1;
      req_excess <= x;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
         if (!calm && $urandom_range(0, 127) == 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            start <= 1'b1;
         end
      end
      pending_prices.push_back(want);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [VALUE_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FLOOR)
         floor_price = value;
      else if (idx == CSR_CONVERSION)
         k_divisor = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain: every item yields a price, so once the queue is empty the unit
   // is done; a few spare cycles let busy fall.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_prices.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Excess shapes: tiny, full range, random width, extremes, and near small
   // multiples of K where the series is most interesting.
   function automatic logic [VALUE_WIDTH-1:0] draw_excess(input logic [VALUE_WIDTH-1:0] k_div);
      logic [VALUE_WIDTH-1:0] r64;
      logic [127:0]           mult, scaled;
      r64 = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: return VALUE_WIDTH'($urandom_range(0, 15));
         1: return r64;
         2: return r64 >> $urandom_range(1, 63);
         3: return ($urandom_range(0, 1) != 0) ? PRICE_SAT : '0;
         default: begin
            if (k_div == '0)
               return r64;
            mult   = 128'($urandom_range(0, 4));
            scaled = {64'd0, k_div} * mult + {64'd0, r64 % k_div};
            return (scaled[127:64] != '0) ? r64 : scaled[VALUE_WIDTH-1:0];
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Directed probes. known rows carry a price that can be read off directly,
   // the rest go through the predictor. poke_spare writes junk to the unused
   // register indexes first.
   // ---------------------------------------------------------------------------
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] base;
      logic [VALUE_WIDTH-1:0] k_div;
      logic [VALUE_WIDTH-1:0] excess;
      bit                     known;
      logic [VALUE_WIDTH-1:0] price;
      bit                     poke_spare;
   } probe_row_type;

   probe_row_type probe_rows [PROBE_COUNT] = '{
      // register values straight out of reset
      '{64'd1, 64'd1, 64'd0, 1'b1, 64'd1, 1'b0},
      '{64'd1, 64'd1, 64'd1, 1'b1, 64'd2, 1'b0},
      '{64'd1, 64'd1, PRICE_SAT, 1'b1, PRICE_SAT, 1'b0},
      '{64'd1, 64'd1, 64'd2, 1'b0, 64'd0, 1'b0},
      // K of zero returns the floor unchanged
      '{64'h0123_4567_89AB_CDEF, 64'd0, PRICE_SAT, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b0},
      '{PRICE_SAT, 64'd0, 64'd0, 1'b1, PRICE_SAT, 1'b0},
      '{64'd0, 64'd0, 64'h5555_5555_5555_5555, 1'b1, 64'd0, 1'b0},
      // zero floor gives zero, spare writes must not leak into the floor price
      '{64'd0, PRICE_SAT, PRICE_SAT, 1'b1, 64'd0, 1'b0},
      '{64'd0, 64'd1, 64'd0, 1'b1, 64'd0, 1'b1},
      // saturation on the very first term, and just below it
      '{PRICE_SAT, 64'd1, 64'd0, 1'b1, PRICE_SAT, 1'b0},
      '{PRICE_SAT, PRICE_SAT, 64'd0, 1'b1, PRICE_SAT, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 64'd1, 64'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0},
      '{64'd1, PRICE_SAT, 64'd0, 1'b1, 64'd1, 1'b0},
      // widest K, series of a few dozen terms
      '{64'd1, PRICE_SAT, PRICE_SAT, 1'b0, 64'd0, 1'b0},
      '{64'd1, PRICE_SAT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 1'b1},
      '{64'd1000, 64'd1000, 64'd1000, 1'b0, 64'd0, 1'b0},
      // e^44 fits, e^45 saturates partway down the series
      '{64'd1, 64'd1, 64'd44, 1'b0, 64'd0, 1'b0},
      '{64'd1, 64'd1, 64'd45, 1'b0, 64'd0, 1'b0},
      '{64'h1_0000_0000, 64'h1_0000_0000, 64'h5_0000_0000, 1'b0, 64'd0, 1'b0},
      // huge floor: ratio 2/3 stays under the ceiling, ratio 1 crosses it
      '{64'h8000_0000_0000_0000, 64'd3, 64'd2, 1'b0, 64'd0, 1'b0},
      '{64'h8000_0000_0000_0000, 64'd3, 64'd3, 1'b0, 64'd0, 1'b0},
      '{64'd7, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
      '{64'h5555_5555_5555_5555, 64'd1, 64'd1, 1'b0, 64'd0, 1'b0}
   };

   initial begin : stimulus
      probe_row_type          row;
      price_estimate_type     est;
      logic [VALUE_WIDTH-1:0] x, r64, want;
      int                     cap;
      bit                     calm;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed probes; registers change only with the unit drained
      for (int i = 0; i < PROBE_COUNT; i++) begin
         row = probe_rows[i];
         if (row.base != floor_price || row.k_div != k_divisor || row.poke_spare) begin
            drain();
            if (row.base != floor_price)
               write_csr(CSR_FLOOR, row.base);
            if (row.k_div != k_divisor)
               write_csr(CSR_CONVERSION, row.k_div);
            if (row.poke_spare) begin
               write_csr(CSR_SPARE_LO, {$urandom, $urandom} | 64'h1);
               write_csr(CSR_SPARE_HI, {$urandom, $urandom} | 64'h1);
            end
         end
         est  = fake_exp_price(row.excess, floor_price, k_divisor);
         want = row.known ? row.price : est.price;
         send_excess(row.excess, want, 1'b0);
      end

      // random phases, one register setting each; last phase runs without idles
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         r64 = {$urandom, $urandom};
         case (phase)
            0: begin
               write_csr(CSR_FLOOR, {$urandom, $urandom});
               write_csr(CSR_CONVERSION, 64'd0);
            end
            1: begin
               write_csr(CSR_FLOOR, VALUE_WIDTH'($urandom_range(0, 4096)));
               write_csr(CSR_CONVERSION, 64'd1);
            end
            2: begin
               write_csr(CSR_FLOOR, VALUE_WIDTH'($urandom_range(1, 1 << 20)));
               write_csr(CSR_CONVERSION, (r64 >> $urandom_range(32, 56)) | 64'd1);
            end
            3: begin
               write_csr(CSR_FLOOR, VALUE_WIDTH'($urandom_range(0, 255)));
               write_csr(CSR_CONVERSION, r64);
            end
            4: begin
               write_csr(CSR_FLOOR, {$urandom, $urandom} >> $urandom_range(40, 63));
               write_csr(CSR_CONVERSION, PRICE_SAT);
            end
            5: begin
               write_csr(CSR_FLOOR, {$urandom, $urandom});
               write_csr(CSR_CONVERSION, r64 >> $urandom_range(0, 60));
            end
            6: begin
               write_csr(CSR_FLOOR, PRICE_SAT);
               write_csr(CSR_CONVERSION, r64 >> $urandom_range(0, 63));
            end
            default: begin
               write_csr(CSR_FLOOR, 64'd0);
               write_csr(CSR_CONVERSION, r64);
            end
         endcase
         calm = (phase == PHASES - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            cap = ($urandom_range(0, 15) == 0) ? DEEP_TERMS : SHORT_TERMS;
            x   = draw_excess(k_divisor);
            est = fake_exp_price(x, floor_price, k_divisor);
            // shrink the exponent until the series fits the budget
            while (est.terms > cap) begin
               x   = x >> $urandom_range(1, 8);
               est = fake_exp_price(x, floor_price, k_divisor);
            end
            send_excess(x, est.price, calm);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_prices.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fault_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== fake_exponential_price_unit.f =====
src/fep_pkg.sv
src/fep_muldiv.sv
src/fake_exponential_price_unit.sv
sim/tb_fake_exponential_price_unit.sv
